// ===== hw/rtl/tcw_pkg.sv =====
// Package for the text console writer: request/result structs, sequencer
// states and character codes. No dependencies.
package tcw_pkg;

	// character codes
	localparam logic [7:0] CH_LOW     = 8'd31;
	localparam logic [7:0] CH_HIGH    = 8'd127;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_code;
		logic       end_of_string;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} req_t;

	typedef struct packed {
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic [7:0] cell_char;
		logic       scrolled;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_FINISH
	} state_t;

endpackage

// ===== hw/rtl/text_console_writer_unit.sv =====
// Text console writer: character plane with cursor, wrap and scroll.
// A plain write or read passes through the finish state to a registered result strobe;
// a new request is taken only when idle with no write pending. A request that scrolls
// copies the rows up, one cell a cycle over the single memory port pair, then blanks the
// bottom row. After reset the plane is cleared to spaces, one cell a cycle, while busy
// is high. The result strobe lasts one cycle; the receiver cannot stall.
module text_console_writer_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tcw_pkg::req_t req,
	output logic          done,
	output tcw_pkg::rsp_t rsp
);
	import tcw_pkg::*;

	localparam int DEPTH      = ROWS * COLUMNS;
	localparam int AW         = $clog2(DEPTH);
	localparam int CW         = $clog2(COLUMNS + 1);
	localparam int RW         = $clog2(ROWS);
	localparam int SCROLL_N   = (ROWS - 1) * COLUMNS;
	localparam int BLANK_BASE = (ROWS - 1) * COLUMNS;

	// character memory
	logic [7:0]    mem [DEPTH];
	logic [7:0]    rd_data_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	// write pipeline stage
	logic          wr_pend_s1;
	logic [AW-1:0] wr_addr_s1;
	logic [7:0]    wr_char_s1;
	logic          wr_copy_s1;
	logic          wr_req;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_char;
	logic          wr_copy;

	// sequencer and cursor state
	state_t        state_q, state_nxt;
	logic [AW-1:0] cnt_q;
	logic          cnt_last;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          scr_q;
	logic          is_rd_q;
	logic          rd_ok_q;
	logic          hold_q;
	logic [7:0]    hold_char_q;
	logic          done_q;
	rsp_t          rsp_q;

	// request decode
	logic          accept;
	logic          is_nl, is_pr, pend, at_bottom, pre_scroll, post_wrap, post_scroll;
	logic          rd_ok, do_scroll;
	logic [CW-1:0] col1, col2, col_fin;
	logic [RW-1:0] row1, row_fin;
	logic [RW-1:0] addr_row;
	logic [CW-1:0] addr_col;
	logic [AW-1:0] mul_addr;

	assign busy   = (state_q != ST_IDLE) || wr_pend_s1;
	assign accept = start && !busy;

	// cursor update for a write request
	always_comb begin
		is_nl       = (req.char_code == CH_NEWLINE);
		is_pr       = (req.char_code > CH_LOW) && (req.char_code < CH_HIGH);
		pend        = (col_q >= CW'(COLUMNS));
		at_bottom   = (row_q == RW'(ROWS - 1));
		pre_scroll  = !is_nl && pend && at_bottom;
		col1        = pend ? '0 : col_q;
		row1        = (pend && !at_bottom) ? row_q + 1'b1 : row_q;
		col2        = col1 + 1'b1;
		post_wrap   = !is_nl && is_pr && (col2 == CW'(COLUMNS)) && req.end_of_string;
		post_scroll = post_wrap && (row1 == RW'(ROWS - 1));
		if (is_nl) begin
			col_fin = '0;
			row_fin = at_bottom ? row_q : row_q + 1'b1;
		end else if (post_wrap) begin
			col_fin = '0;
			row_fin = post_scroll ? row1 : row1 + 1'b1;
		end else if (is_pr) begin
			col_fin = col2;
			row_fin = row1;
		end else begin
			col_fin = col1;
			row_fin = row1;
		end
		do_scroll = (is_nl && at_bottom) || pre_scroll || post_scroll;
		rd_ok     = (32'(req.read_row) < ROWS) && (32'(req.read_col) < COLUMNS);
	end

	// shared cell address: row * COLUMNS + col, for reads and stores
	always_comb begin
		if (req.req_type == REQ_READ) begin
			addr_row = RW'(req.read_row);
			addr_col = CW'(req.read_col);
		end else begin
			addr_row = row1;
			addr_col = col1;
		end
		mul_addr = AW'(AW'(addr_row) * AW'(COLUMNS) + AW'(addr_col));
	end

	// counter end per sweep
	always_comb begin
		unique case (state_q)
			ST_CLEAR:  cnt_last = (cnt_q == AW'(DEPTH - 1));
			ST_SCROLL: cnt_last = (cnt_q == AW'(SCROLL_N - 1));
			ST_BLANK:  cnt_last = (cnt_q == AW'(COLUMNS - 1));
			default:   cnt_last = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (cnt_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_WRITE && do_scroll) state_nxt = ST_SCROLL;
					else state_nxt = ST_FINISH;
				end
			end
			ST_SCROLL: begin
				if (cnt_last) state_nxt = ST_BLANK;
			end
			ST_BLANK: begin
				if (cnt_last) state_nxt = ST_FINISH;
			end
			ST_FINISH: state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// memory port requests
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mul_addr;
		wr_req  = 1'b0;
		wr_addr = cnt_q;
		wr_char = CH_SPACE;
		wr_copy = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_req = 1'b1;
			end
			ST_IDLE: begin
				if (accept && req.req_type == REQ_READ) begin
					rd_en = rd_ok;
				end else if (accept && is_pr && !pre_scroll) begin
					wr_req  = 1'b1;
					wr_addr = mul_addr;
					wr_char = req.char_code;
				end
			end
			ST_SCROLL: begin
				rd_en   = 1'b1;
				rd_addr = cnt_q + AW'(COLUMNS);
				wr_req  = 1'b1;
				wr_copy = 1'b1;
			end
			ST_BLANK: begin
				wr_req  = 1'b1;
				wr_addr = AW'(BLANK_BASE) + cnt_q;
				if (cnt_q == '0 && hold_q) wr_char = hold_char_q;
			end
			default: ;
		endcase
	end

	// memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_pend_s1) mem[wr_addr_s1] <= wr_copy_s1 ? rd_data_q : wr_char_s1;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	// write stage payload
	always_ff @(posedge clk) begin
		wr_addr_s1 <= wr_addr;
		wr_char_s1 <= wr_char;
		wr_copy_s1 <= wr_copy;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			wr_pend_s1 <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			wr_pend_s1 <= wr_req;
			done_q     <= (state_q == ST_FINISH);
			if (state_q == ST_CLEAR || state_q == ST_SCROLL || state_q == ST_BLANK) begin
				cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
			end
			if (accept && req.req_type == REQ_WRITE) begin
				col_q <= col_fin;
				row_q <= row_fin;
			end
		end
	end

	// per-request flags
	always_ff @(posedge clk) begin
		if (accept) begin
			is_rd_q     <= (req.req_type == REQ_READ);
			rd_ok_q     <= rd_ok;
			scr_q       <= (req.req_type == REQ_WRITE) && do_scroll;
			hold_q      <= is_pr && pre_scroll;
			hold_char_q <= req.char_code;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH) begin
			rsp_q.cursor_col <= 7'(col_q);
			rsp_q.cursor_row <= 5'(row_q);
			rsp_q.cell_char  <= (is_rd_q && rd_ok_q) ? rd_data_q : 8'd0;
			rsp_q.scrolled   <= scr_q;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef NO_ASSERTIONS
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FINISH))
		else $error("result strobe without finish state");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) <= COLUMNS)
		else $error("cursor column out of range");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < ROWS)
		else $error("cursor row out of range");
	a_wr_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_pend_s1 |-> (32'(wr_addr_s1) < DEPTH))
		else $error("write address out of range");
	a_no_copy_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && wr_pend_s1) |-> (rd_addr != wr_addr_s1))
		else $error("scroll read collides with pending write");
`endif

endmodule
